>>> hw/rtl/rmvg_pkg.sv
// Shared constants, types and tables of the ring mesh vertex generator.
package rmvg_pkg;

  localparam int SEG_W      = 11;
  localparam int NPHI_W     = 12;
  localparam int RAD_W      = 16;
  localparam int ANG_W      = 16;
  localparam int SWEEP_W    = 17;
  localparam int IDX_W      = 21;
  localparam int POS_W      = 17;
  localparam int TEX_W      = 16;
  localparam int TRIG_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 88;

  localparam int MAX_SEGMENTS     = 1024;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUAD_BEATS       = 6;

  localparam logic signed [TRIG_W-1:0] TRIG_ONE  = 32'sd1073741824;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 32'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_SEG  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIAL_SEG = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SWEEP      = 3'd5;

  localparam logic CMD_VERTEX = 1'b0;
  localparam logic CMD_QUAD   = 1'b1;

  localparam logic [SEG_W-1:0]   RST_ANGLE_SEG  = 11'd32;
  localparam logic [SEG_W-1:0]   RST_RADIAL_SEG = 11'd1;
  localparam logic [RAD_W-1:0]   RST_INNER      = 16'd128;
  localparam logic [RAD_W-1:0]   RST_OUTER      = 16'd256;
  localparam logic [ANG_W-1:0]   RST_START      = 16'd0;
  localparam logic [SWEEP_W-1:0] RST_SWEEP      = 17'd65536;

  typedef struct packed {
    logic              cmd;
    logic              err;
    logic [IDX_W-1:0]  idx;
    logic [NPHI_W-1:0] nphi;
  } tag_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic signed [TRIG_W-1:0] atan_turn(input logic [4:0] k);
    logic signed [TRIG_W-1:0] v;
    case (k)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41721;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/ring_mesh_vertex_generator_core.sv
// Top level of the ring mesh vertex generator: config, pipeline and output sequencer.
//
//   channel | dir | handshake            | payload
//   in      | in  | in_tvalid/in_tready  | tdata: ring_step, radial_step; tuser: command
//   out     | out | out_tvalid/out_tready| tdata: pos, tex, vertex_index; tlast; tuser
//   cfg     | in  | cfg_we               | cfg_addr, cfg_wdata
//
// One request enters per cycle unless the output stalls or sends a non-final quad beat.
// Its path: 30-stage angle/radius divider, CORDIC stages, 16-stage texture divider.
// A quad request holds the output register until its last index beat is taken.
// Reset (synchronous) clears valid bits and loads register defaults.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
module ring_mesh_vertex_generator_core
  import rmvg_pkg::*;
#(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // ring_step, radial_step
  input  logic                  in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // pos_x, pos_y, tex_u, tex_v, vertex_index
  output logic                  out_tlast,
  output logic                  out_tuser,  // error_flag
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int TAG_W = $bits(tag_t);
  localparam int DIV_W = 30;

  logic [SEG_W-1:0]   aseg_r, rseg_r;
  logic [RAD_W-1:0]   inner_r, outer_r;
  logic [ANG_W-1:0]   start_r;
  logic [SWEEP_W-1:0] sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      aseg_r  <= RST_ANGLE_SEG;
      rseg_r  <= RST_RADIAL_SEG;
      inner_r <= RST_INNER;
      outer_r <= RST_OUTER;
      start_r <= RST_START;
      sweep_r <= RST_SWEEP;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_ANGLE_SEG:  aseg_r  <= cfg_wdata[SEG_W-1:0];
        REG_RADIAL_SEG: rseg_r  <= cfg_wdata[SEG_W-1:0];
        REG_INNER:      inner_r <= cfg_wdata[RAD_W-1:0];
        REG_OUTER:      outer_r <= cfg_wdata[RAD_W-1:0];
        REG_START:      start_r <= cfg_wdata[ANG_W-1:0];
        REG_SWEEP:      sweep_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic pipe_en;
  assign in_tready = pipe_en;

  // stage 1: range check and products
  logic [SEG_W-1:0]  ring_w, radial_w;
  logic [NPHI_W-1:0] nphi_w;
  logic [RAD_W-1:0]  span_w;
  logic              setup_ok_w, err_w;

  assign ring_w   = in_tdata[10:0];
  assign radial_w = in_tdata[21:11];
  assign nphi_w   = NPHI_W'(rseg_r) + 12'd1;
  assign span_w   = outer_r - inner_r;
  assign setup_ok_w = (aseg_r >= 11'd3) && (32'(aseg_r) <= MAX_SEGMENTS) &&
                      (rseg_r >= 11'd1) && (32'(rseg_r) <= MAX_SEGMENTS) &&
                      (inner_r < outer_r);
  assign err_w = !setup_ok_w ||
                 ((in_tuser == CMD_VERTEX) ? ((ring_w > aseg_r) || (radial_w > rseg_r))
                                           : ((ring_w >= aseg_r) || (radial_w >= rseg_r)));

  logic        s1_vld_r, s1_cmd_r, s1_err_r;
  logic [27:0] s1_pa_r;
  logic [26:0] s1_pr_r;
  logic [22:0] s1_base_r;
  logic [SEG_W-1:0]  s1_j_r;
  logic [NPHI_W-1:0] s1_nphi_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      s1_cmd_r  <= in_tuser;
      s1_err_r  <= err_w;
      s1_pa_r   <= 28'(ring_w) * 28'(sweep_r);
      s1_pr_r   <= 27'(radial_w) * 27'(span_w);
      s1_base_r <= 23'(ring_w) * 23'(nphi_w);
      s1_j_r    <= radial_w;
      s1_nphi_r <= nphi_w;
    end
  end

  // dividers for angle step and radius step
  logic [DIV_W-1:0] num_a_w, num_r_w;
  logic [IDX_W-1:0] idx_w;
  logic [1:0]       da_side_in, da_side;
  logic [IDX_W+NPHI_W-1:0] dr_side_in, dr_side;
  logic [DIV_W-1:0] quo_a, quo_r;
  logic             da_vld, dr_vld;

  assign num_a_w    = DIV_W'({s1_pa_r, 1'b0}) + DIV_W'(aseg_r);
  assign num_r_w    = DIV_W'({s1_pr_r, 1'b0}) + DIV_W'(rseg_r);
  assign idx_w      = IDX_W'(s1_base_r + 23'(s1_j_r));
  assign da_side_in = {s1_cmd_r, s1_err_r};
  assign dr_side_in = {idx_w, s1_nphi_r};

  rmvg_div #(.NW(DIV_W), .DW(SEG_W+1), .QW(DIV_W), .SW(2)) u_div_ang (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_vld(s1_vld_r),
    .in_num(num_a_w), .in_den({aseg_r, 1'b0}), .in_side(da_side_in),
    .out_vld(da_vld), .out_quo(quo_a), .out_side(da_side)
  );

  rmvg_div #(.NW(DIV_W), .DW(SEG_W+1), .QW(DIV_W), .SW(IDX_W+NPHI_W)) u_div_rad (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_vld(s1_vld_r),
    .in_num(num_r_w), .in_den({rseg_r, 1'b0}), .in_side(dr_side_in),
    .out_vld(dr_vld), .out_quo(quo_r), .out_side(dr_side)
  );

  tag_t             d_tag;
  logic [ANG_W-1:0] ang_w;
  logic [RAD_W-1:0] radius_w;

  assign d_tag    = tag_t'({da_side, dr_side});
  assign ang_w    = start_r + quo_a[ANG_W-1:0];
  assign radius_w = inner_r + quo_r[RAD_W-1:0];

  // CORDIC
  logic                     c_vld;
  logic signed [TRIG_W-1:0] c_cos, c_sin;
  logic [RAD_W+TAG_W-1:0]   c_side;
  logic [RAD_W-1:0]         c_radius;
  tag_t                     c_tag;

  rmvg_cordic #(.STEPS(CORDIC_STEPS), .SW(RAD_W+TAG_W)) u_cordic (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_vld(da_vld & dr_vld),
    .in_ang(ang_w), .in_side({radius_w, d_tag}),
    .out_vld(c_vld), .out_cos(c_cos), .out_sin(c_sin), .out_side(c_side)
  );

  assign c_radius = c_side[RAD_W+TAG_W-1:TAG_W];
  assign c_tag    = tag_t'(c_side[TAG_W-1:0]);

  // multiply, round, texture numerator
  logic               m_vld_r, p1_vld_r, p2_vld_r;
  logic signed [48:0] m_pc_r, m_ps_r;
  tag_t               m_tag_r, p1_tag_r, p2_tag_r;
  logic signed [49:0] rnd_c_w, rnd_s_w, outer_hi_w, p1_tc_r, p1_ts_r;
  logic [POS_W-1:0]   p1_px_r, p1_py_r, p2_px_r, p2_py_r;
  logic [49:0]        nc_w, ns_w, nfc_w, nfs_w;
  logic [32:0]        p2_nu_r, p2_nv_r;
  logic               p2_su_r, p2_sv_r;

  assign rnd_c_w    = 50'(m_pc_r) + (50'sd1 <<< 29);
  assign rnd_s_w    = 50'(m_ps_r) + (50'sd1 <<< 29);
  assign outer_hi_w = signed'(50'({outer_r, 30'b0}));
  assign nc_w       = p1_tc_r[49] ? '0 : unsigned'(p1_tc_r);
  assign ns_w       = p1_ts_r[49] ? '0 : unsigned'(p1_ts_r);
  assign nfc_w      = nc_w + 50'({outer_r, 14'b0});
  assign nfs_w      = ns_w + 50'({outer_r, 14'b0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r  <= 1'b0;
      p1_vld_r <= 1'b0;
      p2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      m_vld_r  <= c_vld;
      p1_vld_r <= m_vld_r;
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      m_pc_r   <= signed'({1'b0, c_radius}) * c_cos;
      m_ps_r   <= signed'({1'b0, c_radius}) * c_sin;
      m_tag_r  <= c_tag;
      p1_tc_r  <= 50'(m_pc_r) + outer_hi_w;
      p1_ts_r  <= 50'(m_ps_r) + outer_hi_w;
      p1_px_r  <= rnd_c_w[46:30];
      p1_py_r  <= rnd_s_w[46:30];
      p1_tag_r <= m_tag_r;
      p2_nu_r  <= nfc_w[47:15];
      p2_nv_r  <= nfs_w[47:15];
      p2_su_r  <= nfc_w[47:15] >= 33'({outer_r, 16'b0});
      p2_sv_r  <= nfs_w[47:15] >= 33'({outer_r, 16'b0});
      p2_px_r  <= p1_px_r;
      p2_py_r  <= p1_py_r;
      p2_tag_r <= p1_tag_r;
    end
  end

  // texture dividers
  localparam int TU_SW = 2*POS_W + 2;
  logic             tu_vld, tv_vld;
  logic [TEX_W-1:0] tu_quo, tv_quo;
  logic [TU_SW-1:0] tu_side;
  logic [TAG_W-1:0] tv_side;

  rmvg_div #(.NW(33), .DW(RAD_W), .QW(TEX_W), .SW(TU_SW)) u_div_u (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_vld(p2_vld_r),
    .in_num(p2_nu_r), .in_den(outer_r),
    .in_side({p2_px_r, p2_py_r, p2_su_r, p2_sv_r}),
    .out_vld(tu_vld), .out_quo(tu_quo), .out_side(tu_side)
  );

  rmvg_div #(.NW(33), .DW(RAD_W), .QW(TEX_W), .SW(TAG_W)) u_div_v (
    .clk(clk), .rst_n(rst_n), .en(pipe_en), .in_vld(p2_vld_r),
    .in_num(p2_nv_r), .in_den(outer_r), .in_side(p2_tag_r),
    .out_vld(tv_vld), .out_quo(tv_quo), .out_side(tv_side)
  );

  tag_t t_tag;
  assign t_tag = tag_t'(tv_side);

  // output register and quad sequencer
  logic             ov_r, o_cmd_r, o_err_r;
  logic [POS_W-1:0] o_px_r, o_py_r;
  logic [TEX_W-1:0] o_tu_r, o_tv_r;
  logic [IDX_W-1:0] o_a_r, o_d_r;
  logic [2:0]       beat_r;
  logic             last_w;

  assign last_w  = o_err_r || (o_cmd_r == CMD_VERTEX) || (beat_r == 3'(QUAD_BEATS - 1));
  assign pipe_en = !ov_r || (out_tready && last_w);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r   <= 1'b0;
      beat_r <= '0;
    end else if (pipe_en) begin
      ov_r   <= tu_vld & tv_vld;
      beat_r <= '0;
    end else if (out_tready) begin
      beat_r <= beat_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      o_cmd_r <= t_tag.cmd;
      o_err_r <= t_tag.err;
      o_px_r  <= tu_side[TU_SW-1:POS_W+2];
      o_py_r  <= tu_side[POS_W+1:2];
      o_tu_r  <= tu_side[1] ? '1 : tu_quo;
      o_tv_r  <= tu_side[0] ? '1 : tv_quo;
      o_a_r   <= t_tag.idx;
      o_d_r   <= t_tag.idx + IDX_W'(t_tag.nphi);
    end
  end

  logic [POS_W-1:0] f_px, f_py;
  logic [TEX_W-1:0] f_tu, f_tv;
  logic [IDX_W-1:0] f_idx;

  always_comb begin
    f_px  = '0;
    f_py  = '0;
    f_tu  = '0;
    f_tv  = '0;
    f_idx = '0;
    if (!o_err_r) begin
      if (o_cmd_r == CMD_VERTEX) begin
        f_px  = o_px_r;
        f_py  = o_py_r;
        f_tu  = o_tu_r;
        f_tv  = o_tv_r;
        f_idx = o_a_r;
      end else begin
        case (beat_r)
          3'd0:    f_idx = o_a_r;
          3'd1:    f_idx = o_a_r + IDX_W'(1);
          3'd2:    f_idx = o_d_r + IDX_W'(1);
          3'd3:    f_idx = o_a_r;
          3'd4:    f_idx = o_d_r + IDX_W'(1);
          3'd5:    f_idx = o_d_r;
          default: f_idx = '0;
        endcase
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tlast  = last_w;
  assign out_tuser  = o_err_r;
  assign out_tdata  = {1'b0, f_idx, f_tv, f_tu, f_py, f_px};

endmodule

>>> hw/rtl/rmvg_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module rmvg_div #(
  parameter int NW = 30,
  parameter int DW = 12,
  parameter int QW = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  localparam int CW = NW + DW + QW;

  logic [QW-1:0] vld_r;
  logic [NW-1:0] rem_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  logic [NW-1:0] rem_src  [QW];
  logic [DW-1:0] den_src  [QW];
  logic [QW-1:0] quo_src  [QW];
  logic [SW-1:0] side_src [QW];
  logic [NW-1:0] rem_nxt  [QW];
  logic [QW-1:0] quo_nxt  [QW];

  always_comb begin
    rem_src[0]  = in_num;
    den_src[0]  = in_den;
    quo_src[0]  = '0;
    side_src[0] = in_side;
    for (int s = 1; s < QW; s++) begin
      rem_src[s]  = rem_r[s-1];
      den_src[s]  = den_r[s-1];
      quo_src[s]  = quo_r[s-1];
      side_src[s] = side_r[s-1];
    end
  end

  always_comb begin
    logic [CW-1:0] trial;
    logic [CW-1:0] shifted;
    for (int s = 0; s < QW; s++) begin
      trial   = CW'(rem_src[s]);
      shifted = CW'(den_src[s]) << (QW - 1 - s);
      if (trial >= shifted) begin
        rem_nxt[s] = NW'(trial - shifted);
        quo_nxt[s] = quo_src[s] | (QW'(1) << (QW - 1 - s));
      end else begin
        rem_nxt[s] = rem_src[s];
        quo_nxt[s] = quo_src[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QW-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < QW; s++) begin
        rem_r[s]  <= rem_nxt[s];
        den_r[s]  <= den_src[s];
        quo_r[s]  <= quo_nxt[s];
        side_r[s] <= side_src[s];
      end
    end
  end

  assign out_vld  = vld_r[QW-1];
  assign out_quo  = quo_r[QW-1];
  assign out_side = side_r[QW-1];

endmodule

>>> hw/rtl/rmvg_cordic.sv
// Pipelined CORDIC rotator, one step per stage, clamp and quadrant stage at the end.
module rmvg_cordic
  import rmvg_pkg::*;
#(
  parameter int STEPS = CORDIC_STEPS_DEF,
  parameter int SW    = 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [ANG_W-1:0]         in_ang,
  input  logic [SW-1:0]            in_side,
  output logic                     out_vld,
  output logic signed [TRIG_W-1:0] out_cos,
  output logic signed [TRIG_W-1:0] out_sin,
  output logic [SW-1:0]            out_side
);

  logic [STEPS-1:0]         vld_r;
  logic signed [TRIG_W-1:0] x_r    [STEPS];
  logic signed [TRIG_W-1:0] y_r    [STEPS];
  logic signed [TRIG_W-1:0] z_r    [STEPS];
  logic [1:0]               quad_r [STEPS];
  logic [SW-1:0]            side_r [STEPS];

  logic signed [TRIG_W-1:0] x_src    [STEPS];
  logic signed [TRIG_W-1:0] y_src    [STEPS];
  logic signed [TRIG_W-1:0] z_src    [STEPS];
  logic [1:0]               quad_src [STEPS];
  logic [SW-1:0]            side_src [STEPS];
  logic signed [TRIG_W-1:0] x_nxt    [STEPS];
  logic signed [TRIG_W-1:0] y_nxt    [STEPS];
  logic signed [TRIG_W-1:0] z_nxt    [STEPS];

  logic                     ov_r;
  logic signed [TRIG_W-1:0] cos_r, sin_r, cos_nxt, sin_nxt;
  logic [SW-1:0]            oside_r;

  always_comb begin
    x_src[0]    = CORDIC_X0;
    y_src[0]    = '0;
    z_src[0]    = signed'({2'b00, in_ang[13:0], 16'h0000});
    quad_src[0] = in_ang[15:14];
    side_src[0] = in_side;
    for (int s = 1; s < STEPS; s++) begin
      x_src[s]    = x_r[s-1];
      y_src[s]    = y_r[s-1];
      z_src[s]    = z_r[s-1];
      quad_src[s] = quad_r[s-1];
      side_src[s] = side_r[s-1];
    end
  end

  always_comb begin
    logic signed [TRIG_W-1:0] dx;
    logic signed [TRIG_W-1:0] dy;
    for (int s = 0; s < STEPS; s++) begin
      dx = y_src[s] >>> s;
      dy = x_src[s] >>> s;
      if (!z_src[s][TRIG_W-1]) begin
        x_nxt[s] = x_src[s] - dx;
        y_nxt[s] = y_src[s] + dy;
        z_nxt[s] = z_src[s] - atan_turn(5'(s));
      end else begin
        x_nxt[s] = x_src[s] + dx;
        y_nxt[s] = y_src[s] - dy;
        z_nxt[s] = z_src[s] + atan_turn(5'(s));
      end
    end
  end

  always_comb begin
    logic signed [TRIG_W-1:0] cc;
    logic signed [TRIG_W-1:0] ss;
    cc = x_r[STEPS-1];
    ss = y_r[STEPS-1];
    if (cc > TRIG_ONE) cc = TRIG_ONE;
    if (cc < -TRIG_ONE) cc = -TRIG_ONE;
    if (ss > TRIG_ONE) ss = TRIG_ONE;
    if (ss < -TRIG_ONE) ss = -TRIG_ONE;
    case (quad_r[STEPS-1])
      2'd0: begin cos_nxt = cc;  sin_nxt = ss;  end
      2'd1: begin cos_nxt = -ss; sin_nxt = cc;  end
      2'd2: begin cos_nxt = -cc; sin_nxt = -ss; end
      default: begin cos_nxt = ss; sin_nxt = -cc; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      ov_r  <= 1'b0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-2:0], in_vld};
      ov_r  <= vld_r[STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < STEPS; s++) begin
        x_r[s]    <= x_nxt[s];
        y_r[s]    <= y_nxt[s];
        z_r[s]    <= z_nxt[s];
        quad_r[s] <= quad_src[s];
        side_r[s] <= side_src[s];
      end
      cos_r   <= cos_nxt;
      sin_r   <= sin_nxt;
      oside_r <= side_r[STEPS-1];
    end
  end

  assign out_vld  = ov_r;
  assign out_cos  = cos_r;
  assign out_sin  = sin_r;
  assign out_side = oside_r;

endmodule
